>>> rtl/core/oqe_pkg.sv
// oqe_pkg: shared types and codes for the ordered queue engine
// holds the transaction structs, the memory strobe struct, operation codes and status codes
// no dependencies
package oqe_pkg;

    // fixed field widths
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int TOTAL_W = 5;

    // operation codes
    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_REM_HEAD = 3'd1;
    localparam logic [2:0] MODE_REM_KEY  = 3'd2;
    localparam logic [2:0] MODE_REM_DATA = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    // request transaction
    typedef struct packed {
        logic [2:0]        mode;
        logic [KEY_W-1:0]  item_key;
        logic [DATA_W-1:0] item_data;
    } req_t;

    // result transaction
    typedef struct packed {
        logic [1:0]         status;
        logic [DATA_W-1:0]  removed_data;
        logic [KEY_W-1:0]   front_key;
        logic [DATA_W-1:0]  front_data;
        logic [TOTAL_W-1:0] entry_total;
    } rsp_t;

    // memory port strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

>>> rtl/core/oqe_store.sv
// oqe_store: key and data memories of the queue, one write and one read port
// read data is registered; uses oqe_pkg
module oqe_store #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  oqe_pkg::mem_ctl_t            mem_ctl,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [oqe_pkg::KEY_W-1:0]    wr_key,
    input  logic [oqe_pkg::DATA_W-1:0]   wr_data,
    output logic [oqe_pkg::KEY_W-1:0]    rd_key,
    output logic [oqe_pkg::DATA_W-1:0]   rd_data
);

    logic [oqe_pkg::KEY_W-1:0]  key_mem  [DEPTH];
    logic [oqe_pkg::DATA_W-1:0] data_mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            data_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_key  <= key_mem[rd_addr];
            rd_data <= data_mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/oqe_cmp.sv
// oqe_cmp: the shared compare unit used on every scanned cell
// decides whether the cell ends the scan for the current operation; uses oqe_pkg
module oqe_cmp (
    input  logic [2:0]                 mode,
    input  logic [oqe_pkg::KEY_W-1:0]  op_key,
    input  logic [oqe_pkg::DATA_W-1:0] op_data,
    input  logic [oqe_pkg::KEY_W-1:0]  cell_key,
    input  logic [oqe_pkg::DATA_W-1:0] cell_data,
    output logic                       hit
);

    // insert stops at the first greater key, removals at the first match
    always_comb
    begin
        unique case (mode)
            oqe_pkg::MODE_INSERT:   hit = (op_key < cell_key);
            oqe_pkg::MODE_REM_HEAD: hit = 1'b1;
            oqe_pkg::MODE_REM_KEY:  hit = (cell_key == op_key);
            oqe_pkg::MODE_REM_DATA: hit = (cell_data == op_data);
            default:                hit = 1'b0;
        endcase
    end

endmodule

>>> rtl/core/oqe_ctrl.sv
// oqe_ctrl: sequencer that scans, shifts and rewrites the queue one cell at a time
// drives the memory port and builds the result; uses oqe_pkg and oqe_cmp
module oqe_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  oqe_pkg::req_t                req,
    input  logic                         ordered,
    output logic                         busy,
    output logic                         done,
    output oqe_pkg::rsp_t                rsp,
    output oqe_pkg::mem_ctl_t            mem_ctl,
    output logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [$clog2(DEPTH)-1:0]     wr_addr,
    output logic [oqe_pkg::KEY_W-1:0]    wr_key,
    output logic [oqe_pkg::DATA_W-1:0]   wr_data,
    input  logic [oqe_pkg::KEY_W-1:0]    rd_key,
    input  logic [oqe_pkg::DATA_W-1:0]   rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_SCAN_RD   = 11'b000_0000_0010,
        S_SCAN_CMP  = 11'b000_0000_0100,
        S_SHIFT_RD  = 11'b000_0000_1000,
        S_SHIFT_WR  = 11'b000_0001_0000,
        S_PUT       = 11'b000_0010_0000,
        S_DROP_RD   = 11'b000_0100_0000,
        S_DROP_WR   = 11'b000_1000_0000,
        S_HEAD_RD   = 11'b001_0000_0000,
        S_HEAD_WAIT = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [2:0]                 mode_reg, mode_next;
    logic [oqe_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [oqe_pkg::DATA_W-1:0] data_reg, data_next;
    logic [1:0]                 status_reg, status_next;
    logic [oqe_pkg::DATA_W-1:0] removed_reg, removed_next;
    logic [oqe_pkg::KEY_W-1:0]  fkey_reg, fkey_next;
    logic [oqe_pkg::DATA_W-1:0] fdata_reg, fdata_next;

    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_p1;
    logic          hit;

    assign idx_m1 = idx_reg - CW'(1);
    assign idx_p1 = idx_reg + CW'(1);

    // shared compare unit on the cell just read
    oqe_cmp u_cmp (
        .mode      (mode_reg),
        .op_key    (key_reg),
        .op_data   (data_reg),
        .cell_key  (rd_key),
        .cell_data (rd_data),
        .hit       (hit)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        data_next    = data_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        fkey_next    = fkey_reg;
        fdata_next   = fdata_reg;
        mem_ctl      = '0;
        rd_addr      = '0;
        wr_addr      = '0;
        wr_key       = key_reg;
        wr_data      = data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next    = req.mode;
                    key_next     = req.item_key;
                    data_next    = req.item_data;
                    status_next  = oqe_pkg::ST_OK;
                    removed_next = '0;
                    idx_next     = '0;
                    unique case (req.mode) inside
                        oqe_pkg::MODE_INSERT:
                        begin
                            if (req.item_data == '0)
                            begin
                                status_next = oqe_pkg::ST_ZERO;
                                state_next  = S_HEAD_RD;
                            end
                            else if (count_reg == CW'(DEPTH))
                            begin
                                status_next = oqe_pkg::ST_FULL;
                                state_next  = S_HEAD_RD;
                            end
                            else if (ordered)
                            begin
                                state_next = S_SCAN_RD;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                idx_next   = count_reg;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        oqe_pkg::MODE_REM_HEAD, oqe_pkg::MODE_REM_KEY,
                        oqe_pkg::MODE_REM_DATA:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        oqe_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_HEAD_RD;
                        end
                        default:
                        begin
                            state_next = S_HEAD_RD;
                        end
                    endcase
                end
            end
            // read the next cell, or finish the scan at the tail
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (mode_reg == oqe_pkg::MODE_INSERT)
                    begin
                        pos_next   = count_reg;
                        idx_next   = count_reg;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        status_next = oqe_pkg::ST_MISS;
                        state_next  = S_HEAD_RD;
                    end
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = idx_reg[AW-1:0];
                    state_next    = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (hit)
                begin
                    pos_next = idx_reg;
                    if (mode_reg == oqe_pkg::MODE_INSERT)
                    begin
                        idx_next   = count_reg;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        removed_next = rd_data;
                        state_next   = S_DROP_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = S_SCAN_RD;
                end
            end
            // open a hole at the insert position, tail first
            S_SHIFT_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = idx_m1[AW-1:0];
                    state_next    = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = idx_reg[AW-1:0];
                wr_key        = rd_key;
                wr_data       = rd_data;
                idx_next      = idx_m1;
                state_next    = S_SHIFT_RD;
            end
            S_PUT:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = pos_reg[AW-1:0];
                count_next    = count_reg + CW'(1);
                state_next    = S_HEAD_RD;
            end
            // close the gap of a removed cell, head first
            S_DROP_RD:
            begin
                if (idx_p1 == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = idx_p1[AW-1:0];
                    state_next    = S_DROP_WR;
                end
            end
            S_DROP_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = idx_reg[AW-1:0];
                wr_key        = rd_key;
                wr_data       = rd_data;
                idx_next      = idx_p1;
                state_next    = S_DROP_RD;
            end
            // fetch the head for the result
            S_HEAD_RD:
            begin
                if (count_reg == '0)
                begin
                    fkey_next  = '0;
                    fdata_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = '0;
                    state_next    = S_HEAD_WAIT;
                end
            end
            S_HEAD_WAIT:
            begin
                fkey_next  = rd_key;
                fdata_next = rd_data;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        data_reg    <= data_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        fkey_reg    <= fkey_next;
        fdata_reg   <= fdata_next;
    end

    // result transaction
    assign busy             = (state_reg != S_IDLE);
    assign done             = (state_reg == S_DONE);
    assign rsp.status       = status_reg;
    assign rsp.removed_data = removed_reg;
    assign rsp.front_key    = fkey_reg;
    assign rsp.front_data   = fdata_reg;
    assign rsp.entry_total  = oqe_pkg::TOTAL_W'(count_reg);

endmodule

>>> rtl/core/ordered_queue_engine.sv
// ordered_queue_engine: top level of the bounded ordered queue
// holds the mode register and joins the sequencer and the memories; uses oqe_pkg
//
// One transaction is taken when start is high and busy is low; busy then stays
// high until its result has been shown. The result appears on rsp for exactly
// one cycle with done high and cannot be held off, so the receiver must take it
// then. All queue cells live in one key and data store with one read and one
// write port, and every cell visit goes through those ports. An operation runs
// from the accept cycle through a scan over the compared cells and the moves
// of the shifted cells; it then writes any new entry, fetches the head and
// presents the result. The scan stops where the moves start, so compared and
// moved cells never add up to more than DEPTH: an ordered insert into DEPTH-1
// entries that lands before a held entry is the longest operation. The ordered
// register (reset 1) is written with cfg_we and must only change while busy is
// low.
module ordered_queue_engine #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  oqe_pkg::req_t req,
    output logic          busy,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    output logic          done,
    output oqe_pkg::rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                       ordered_reg;
    oqe_pkg::mem_ctl_t          mem_ctl;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [oqe_pkg::KEY_W-1:0]  wr_key;
    logic [oqe_pkg::DATA_W-1:0] wr_data;
    logic [oqe_pkg::KEY_W-1:0]  rd_key;
    logic [oqe_pkg::DATA_W-1:0] rd_data;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            ordered_reg <= cfg_wdata;
        end
    end

    // sequencer with the shared compare unit
    oqe_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .ordered (ordered_reg),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .mem_ctl (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_data (wr_data),
        .rd_key  (rd_key),
        .rd_data (rd_data)
    );

    // queue cells
    oqe_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_data (wr_data),
        .rd_key  (rd_key),
        .rd_data (rd_data)
    );

    // a result only closes a transaction in progress
    a_done_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without a transaction in flight");

    // the engine is free again right after a result
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("engine still busy after result");

    // an accepted transaction occupies the engine
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // an empty queue reports a zero head
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.entry_total == '0 && DEPTH < 32)
            |-> (rsp.front_key == '0 && rsp.front_data == '0))
        else $error("empty queue reported a head entry");

    // a failed operation removes nothing
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != oqe_pkg::ST_OK) |-> (rsp.removed_data == '0))
        else $error("failed operation reported removed data");

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for ordered_queue_engine, a directed table then random phases
// every result is checked against a cycle-free predictor or a table row; needs oqe_pkg and rtl
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH       = 16;
    localparam int OP_LATENCY  = 2 * DEPTH + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_OPS   = 100;

    // modes outside the decoded range
    localparam logic [2:0] MODE_UNUSED_LOW = 3'd5;
    localparam logic [2:0] MODE_UNUSED_TOP = 3'd7;

    // register action taken before a table row
    localparam logic [1:0] ORD_KEEP   = 2'd0;
    localparam logic [1:0] ORD_FIFO   = 2'd1;
    localparam logic [1:0] ORD_SORTED = 2'd2;

    typedef struct packed {
        logic [1:0]    order_wr;
        logic          has_rsp;
        oqe_pkg::req_t op;
        oqe_pkg::rsp_t rsp;
    } table_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    oqe_pkg::req_t req = '0;
    logic          busy;
    logic          cfg_we = 1'b0;
    logic          cfg_wdata = 1'b0;
    logic          done;
    oqe_pkg::rsp_t rsp;

    // predictor copy of the queue and the mode register
    logic [oqe_pkg::KEY_W-1:0]  q_key [DEPTH];
    logic [oqe_pkg::DATA_W-1:0] q_val [DEPTH];
    int                         q_cnt = 0;
    logic                       q_ordered = 1'b1;

    table_row_t                 op_table[$];
    oqe_pkg::rsp_t              outcome_q[$];
    logic [oqe_pkg::KEY_W-1:0]  key_pool [8];
    logic [oqe_pkg::DATA_W-1:0] data_pool [8];
    logic                       idling = 1'b1;
    int                         accepted = 0;
    int                         checked = 0;
    int                         errors = 0;
    int                         settings = 0;
    int                         n_full = 0;
    int                         n_zero = 0;
    int                         n_miss = 0;

    ordered_queue_engine #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // next queue state and result for one operation
    function automatic oqe_pkg::rsp_t queue_op_outcome(input oqe_pkg::req_t r);
        oqe_pkg::rsp_t o;
        int            pos;
        int            i;
        o = '0;
        o.status = oqe_pkg::ST_OK;
        pos = -1;
        case (r.mode) inside
            oqe_pkg::MODE_INSERT:
            begin
                if (r.item_data == '0)
                    o.status = oqe_pkg::ST_ZERO;
                else if (q_cnt >= DEPTH)
                    o.status = oqe_pkg::ST_FULL;
                else
                begin
                    // slot goes before the first strictly greater key
                    pos = q_cnt;
                    if (q_ordered)
                        for (i = q_cnt - 1; i >= 0; i--)
                            if (r.item_key < q_key[i])
                                pos = i;
                    for (i = q_cnt; i > pos; i--)
                    begin
                        q_key[i] = q_key[i-1];
                        q_val[i] = q_val[i-1];
                    end
                    q_key[pos] = r.item_key;
                    q_val[pos] = r.item_data;
                    q_cnt++;
                end
            end
            oqe_pkg::MODE_REM_HEAD:
            begin
                if (q_cnt == 0)
                    o.status = oqe_pkg::ST_MISS;
                else
                    pos = 0;
            end
            oqe_pkg::MODE_REM_KEY, oqe_pkg::MODE_REM_DATA:
            begin
                // first hit from the head wins
                o.status = oqe_pkg::ST_MISS;
                for (i = q_cnt - 1; i >= 0; i--)
                    if ((r.mode == oqe_pkg::MODE_REM_KEY) ? (q_key[i] == r.item_key)
                                                          : (q_val[i] == r.item_data))
                        pos = i;
                if (pos >= 0)
                    o.status = oqe_pkg::ST_OK;
            end
            oqe_pkg::MODE_CLEAR:
                q_cnt = 0;
            default:
                ;
        endcase
        // pull the removed cell out and close the gap
        if (r.mode != oqe_pkg::MODE_INSERT && pos >= 0)
        begin
            o.removed_data = q_val[pos];
            for (i = pos; i < q_cnt - 1; i++)
            begin
                q_key[i] = q_key[i+1];
                q_val[i] = q_val[i+1];
            end
            q_cnt--;
        end
        if (q_cnt > 0)
        begin
            o.front_key  = q_key[0];
            o.front_data = q_val[0];
        end
        o.entry_total = oqe_pkg::TOTAL_W'(q_cnt);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // result checking and prediction at each accepted transaction
    always @(posedge clk)
    begin : rsp_monitor
        oqe_pkg::rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding, actual %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp.status));
                    check_field("removed_data", want.removed_data, rsp.removed_data);
                    check_field("front_key", want.front_key, rsp.front_key);
                    check_field("front_data", want.front_data, rsp.front_data);
                    check_field("entry_total", 32'(want.entry_total), 32'(rsp.entry_total));
                    checked++;
                end
            end
            if (cfg_we)
                q_ordered = cfg_wdata;
            if (start && !busy)
            begin
                want = queue_op_outcome(req);
                if (want.status == oqe_pkg::ST_FULL) n_full++;
                if (want.status == oqe_pkg::ST_ZERO) n_zero++;
                if (want.status == oqe_pkg::ST_MISS) n_miss++;
                // hand-written rows override the predictor
                if (accepted < op_table.size() && op_table[accepted].has_rsp)
                    want = op_table[accepted].rsp;
                outcome_q.push_back(want);
                accepted++;
            end
        end
    end

    task automatic add_row(input logic [1:0] wr, input int reps, input logic [2:0] op_mode,
                           input logic [31:0] k, input logic [31:0] d,
                           input logic has, input oqe_pkg::rsp_t r);
        table_row_t row;
        int         n;
        for (n = 0; n < reps; n++)
        begin
            row.order_wr       = (n == 0) ? wr : ORD_KEEP;
            row.has_rsp        = has;
            row.op.mode        = op_mode;
            row.op.item_key    = k;
            row.op.item_data   = d;
            row.rsp            = r;
            op_table.push_back(row);
        end
    endtask

    // hold start until the transaction is taken
    task automatic issue(input oqe_pkg::req_t r);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    // drop start and wait until the engine has answered everything
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (outcome_q.size() != 0 || busy);
    endtask

    task automatic set_order(input logic v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic maybe_idle();
        int gap;
        if (idling && $urandom_range(99) < 33)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // random operation drawn from small pools so matches are common
    function automatic oqe_pkg::req_t pick_op(input int ins_pct);
        oqe_pkg::req_t r;
        int            roll;
        if ($urandom_range(99) < ins_pct)
            r.mode = oqe_pkg::MODE_INSERT;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                r.mode = oqe_pkg::MODE_REM_HEAD;
            else if (roll < 60)
                r.mode = oqe_pkg::MODE_REM_KEY;
            else if (roll < 90)
                r.mode = oqe_pkg::MODE_REM_DATA;
            else if (roll < 96)
                r.mode = oqe_pkg::MODE_CLEAR;
            else
                r.mode = 3'($urandom_range(MODE_UNUSED_LOW, MODE_UNUSED_TOP));
        end
        r.item_key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(7)] : $urandom();
        roll = $urandom_range(19);
        if (roll == 0)
            r.item_data = '0;
        else if (roll < 15)
            r.item_data = data_pool[$urandom_range(7)];
        else
            r.item_data = $urandom();
        return r;
    endfunction

    initial
    begin : stimulus
        int                         p;
        int                         n;
        logic [oqe_pkg::DATA_W-1:0] v;

        // directed table: empty queue, extremes, misses, unused modes
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_REM_HEAD, 32'h0, 32'h0, 1'b1,
                {oqe_pkg::ST_MISS, 32'h0, 32'h0, 32'h0, 5'd0});
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_INSERT, 32'h10, 32'h0, 1'b1,
                {oqe_pkg::ST_ZERO, 32'h0, 32'h0, 32'h0, 5'd0});
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                {oqe_pkg::ST_OK, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1});
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_INSERT, 32'h0, 32'h1, 1'b1,
                {oqe_pkg::ST_OK, 32'h0, 32'h0, 32'h1, 5'd2});
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_INSERT, 32'h0, 32'h2, 1'b0, '0);
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_REM_DATA, 32'h89AB_CDEF, 32'h0, 1'b0, '0);
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_REM_KEY, 32'h5A5A_5A5A, 32'h0, 1'b0, '0);
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_REM_KEY, 32'h0, 32'h0, 1'b0, '0);
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_REM_DATA, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(ORD_KEEP, 1, MODE_UNUSED_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_CLEAR, 32'h0, 32'h0, 1'b1,
                {oqe_pkg::ST_OK, 32'h0, 32'h0, 32'h0, 5'd0});
        // fifo fill to capacity, then full and zero-data rejects
        add_row(ORD_FIFO, 8, oqe_pkg::MODE_INSERT, 32'hFFFF_0000, 32'h11, 1'b0, '0);
        add_row(ORD_KEEP, 8, oqe_pkg::MODE_INSERT, 32'h3, 32'h22, 1'b0, '0);
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_INSERT, 32'h1, 32'h1, 1'b1,
                {oqe_pkg::ST_FULL, 32'h0, 32'hFFFF_0000, 32'h11, 5'd16});
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_INSERT, 32'h1, 32'h0, 1'b1,
                {oqe_pkg::ST_ZERO, 32'h0, 32'hFFFF_0000, 32'h11, 5'd16});
        // back to sorted with an unsorted queue held
        add_row(ORD_SORTED, 1, oqe_pkg::MODE_REM_HEAD, 32'h0, 32'h0, 1'b1,
                {oqe_pkg::ST_OK, 32'h11, 32'hFFFF_0000, 32'h11, 5'd15});
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_INSERT, 32'h4, 32'h33, 1'b0, '0);
        add_row(ORD_KEEP, 1, MODE_UNUSED_LOW, 32'h4, 32'h33, 1'b0, '0);
        add_row(ORD_KEEP, 1, oqe_pkg::MODE_CLEAR, 32'h0, 32'h0, 1'b1,
                {oqe_pkg::ST_OK, 32'h0, 32'h0, 32'h0, 5'd0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (op_table[i])
        begin
            if (op_table[i].order_wr == ORD_FIFO)
                set_order(1'b0);
            else if (op_table[i].order_wr == ORD_SORTED)
                set_order(1'b1);
            issue(op_table[i].op);
            maybe_idle();
        end

        // random phases, alternating fill pressure, with a register setting chosen per phase
        for (p = 0; p < PHASES; p++)
        begin
            set_order(p == 1 || p == 2 || p == 4);
            for (n = 0; n < 8; n++)
            begin
                key_pool[n] = (n == 0) ? '0 : (n == 1) ? '1 :
                              ($urandom_range(1) ? oqe_pkg::KEY_W'($urandom_range(15))
                                                 : $urandom());
                do v = $urandom(); while (v == '0);
                data_pool[n] = v;
            end
            idling = (p != 2);
            for (n = 0; n < PHASE_OPS; n++)
            begin
                issue(pick_op(p[0] ? 45 : 62));
                if (n == PHASE_OPS / 2 || $urandom_range(39) == 0)
                    settle();
                else
                    maybe_idle();
            end
        end

        settle();
        repeat (2 * OP_LATENCY) @(posedge clk);

        $display("%0d operations accepted, %0d results checked over %0d register writes",
                 accepted, checked, settings);
        $display("outcomes seen: %0d full, %0d zero-data, %0d empty or no match",
                 n_full, n_zero, n_miss);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run length guard
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/oqe_pkg.sv
rtl/core/oqe_store.sv
rtl/core/oqe_cmp.sv
rtl/core/oqe_ctrl.sv
rtl/core/ordered_queue_engine.sv
bench/tb_top.sv
